>>> design/smsl_pkg.sv
// Shared types and codes for the sparse matrix sorted list store.
// Used by smsl_mem, smsl_ctrl and sparse_matrix_sorted_list_store_top.
package smsl_pkg;

    localparam int ROW_W   = 16;
    localparam int COL_W   = 16;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 17;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 17'h10000;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OOB  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

endpackage

>>> design/smsl_mem.sv
// Entry memory: key/value array and link array, one write port each and a
// shared registered read port. Depends on smsl_pkg.
module smsl_mem #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int LW       = 7
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output smsl_pkg::entry_t      rd_entry,
    output logic [LW-1:0]         rd_link,
    input  logic                  ent_wr_en,
    input  logic [AW-1:0]         ent_wr_addr,
    input  smsl_pkg::entry_t      ent_wr_data,
    input  logic                  link_wr_en,
    input  logic [AW-1:0]         link_wr_addr,
    input  logic [LW-1:0]         link_wr_data
);

    smsl_pkg::entry_t ent_mem  [CAPACITY];
    logic [LW-1:0]    link_mem [CAPACITY];

    smsl_pkg::entry_t rd_entry_reg;
    logic [LW-1:0]    rd_link_reg;

    always_ff @(posedge clk)
    begin
        if (ent_wr_en)
        begin
            ent_mem[ent_wr_addr] <= ent_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_wr_en)
        begin
            link_mem[link_wr_addr] <= link_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= ent_mem[rd_addr];
            rd_link_reg  <= link_mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_link  = rd_link_reg;

endmodule

>>> design/smsl_ctrl.sv
// Sequencer: bounds check, list walk with one shared key comparator, then
// update, insert and link steps. Depends on smsl_pkg; drives smsl_mem.
module smsl_ctrl #(
    parameter int CAPACITY = 64,
    parameter int AW       = 6,
    parameter int LW       = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic [smsl_pkg::ROW_W-1:0]            row,
    input  logic [smsl_pkg::COL_W-1:0]            col,
    input  logic signed [smsl_pkg::VALUE_W-1:0]   new_value,
    input  logic [smsl_pkg::COUNT_W-1:0]          row_count,
    input  logic [smsl_pkg::COUNT_W-1:0]          column_count,
    output logic                                  res_valid,
    input  logic                                  res_take,
    output logic signed [smsl_pkg::VALUE_W-1:0]   res_value,
    output logic [1:0]                            res_status,
    output logic                                  rd_en,
    output logic [AW-1:0]                         rd_addr,
    input  smsl_pkg::entry_t                      rd_entry,
    input  logic [LW-1:0]                         rd_link,
    output logic                                  ent_wr_en,
    output logic [AW-1:0]                         ent_wr_addr,
    output smsl_pkg::entry_t                      ent_wr_data,
    output logic                                  link_wr_en,
    output logic [AW-1:0]                         link_wr_addr,
    output logic [LW-1:0]                         link_wr_data
);

    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WALK   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_LINK   = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prev_reg, prev_next;
    logic [LW-1:0] head_reg, head_next;
    logic [LW-1:0] alloc_reg, alloc_next;
    logic hit_reg, hit_next;
    logic signed [smsl_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic [1:0] res_status_reg, res_status_next;

    logic func_reg;
    logic [smsl_pkg::ROW_W-1:0] row_reg;
    logic [smsl_pkg::COL_W-1:0] col_reg;
    logic signed [smsl_pkg::VALUE_W-1:0] value_reg;

    logic accept;
    logic out_of_bounds;
    logic key_below;
    logic key_equal;

    assign accept        = in_valid && in_ready;
    assign out_of_bounds = ({1'b0, row} >= row_count) || ({1'b0, col} >= column_count);

    // The one comparator: stored key against the addressed position
    assign key_below = (rd_entry.row < row_reg) ||
                       ((rd_entry.row == row_reg) && (rd_entry.col < col_reg));
    assign key_equal = (rd_entry.row == row_reg) && (rd_entry.col == col_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            row_reg   <= row;
            col_reg   <= col;
            value_reg <= new_value;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        head_next       = head_reg;
        alloc_next      = alloc_reg;
        hit_next        = hit_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_reg[AW-1:0];
        ent_wr_en       = 1'b0;
        ent_wr_addr     = cur_reg[AW-1:0];
        ent_wr_data     = '{row: row_reg, col: col_reg, value: value_reg};
        link_wr_en      = 1'b0;
        link_wr_addr    = prev_reg[AW-1:0];
        link_wr_data    = alloc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_value_next  = '0;
                    res_status_next = smsl_pkg::STATUS_OK;
                    cur_next        = head_reg;
                    prev_next       = NIL;
                    hit_next        = 1'b0;
                    if (out_of_bounds)
                    begin
                        res_status_next = smsl_pkg::STATUS_OOB;
                        state_next      = S_RESP;
                    end
                    else if (head_reg == NIL)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = head_reg[AW-1:0];
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (key_below)
                begin
                    // advance one link, fetching the next entry at once
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    if (rd_link == NIL)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rd_link[AW-1:0];
                    end
                end
                else
                begin
                    hit_next       = key_equal;
                    res_value_next = key_equal ? rd_entry.value : '0;
                    state_next     = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_RESP;
                if (func_reg == smsl_pkg::FUNC_WRITE)
                begin
                    if (hit_reg)
                    begin
                        ent_wr_en = 1'b1;
                    end
                    else if (alloc_reg == NIL)
                    begin
                        res_status_next = smsl_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        // new slot points at the first larger entry
                        ent_wr_en    = 1'b1;
                        ent_wr_addr  = alloc_reg[AW-1:0];
                        link_wr_en   = 1'b1;
                        link_wr_addr = alloc_reg[AW-1:0];
                        link_wr_data = cur_reg;
                        state_next   = S_LINK;
                    end
                end
            end
            S_LINK:
            begin
                if (prev_reg == NIL)
                begin
                    head_next = alloc_reg;
                end
                else
                begin
                    link_wr_en = 1'b1;
                end
                alloc_next = alloc_reg + 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= NIL;
            alloc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            alloc_reg <= alloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        hit_reg        <= hit_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESP);
    assign res_value  = res_value_reg;
    assign res_status = res_status_reg;

`ifndef ASSERT_OFF
    a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg <= NIL)
        else $error("allocation count beyond capacity");

    a_link_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK |-> $past(state_reg) == S_DECIDE && alloc_reg != NIL)
        else $error("link step without a free slot");

    a_walk_valid_cur: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> cur_reg != NIL && head_reg != NIL)
        else $error("walking a null slot");

    a_alloc_only_in_link: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg != $past(alloc_reg) |-> $past(state_reg) == S_LINK)
        else $error("allocation count moved outside the link step");
`endif

endmodule

>>> design/sparse_matrix_sorted_list_store_top.sv
// Sparse matrix store: dimension registers, sequencer, entry memory and
// result register. Depends on smsl_pkg, smsl_mem and smsl_ctrl.
//
// Usage:
//   Input channel (in_valid/in_ready) carries func, row, col, new_value.
//   func read returns the stored value or zero; func write stores new_value
//   and returns the previous value (zero for a new entry).
//   Output channel (out_valid/out_ready) carries data_value and status:
//   ok, out of bounds (nothing changes) or full (new entry not stored).
//   cfg_write/cfg_index/cfg_data set row_count and column_count; write them
//   only while no transaction is in progress.
// Timing:
//   From acceptance, an item passes the walk, decide and link states as
//   needed, then the response state that hands its result to the output
//   register; the walk covers up to CAPACITY entries and reads one entry
//   per cycle from the single memory read port. A new item is accepted in
//   the cycle after the previous result is handed over.
// Reset: empty matrix, all slots free, both dimensions 65536. No clearing
//   pass is needed. When the receiver stalls, one result waits in the
//   output register and the next finished result holds in the sequencer.
module sparse_matrix_sorted_list_store_top #(
    parameter int CAPACITY = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  func,
    input  logic [smsl_pkg::ROW_W-1:0]            row,
    input  logic [smsl_pkg::COL_W-1:0]            col,
    input  logic signed [smsl_pkg::VALUE_W-1:0]   new_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [smsl_pkg::VALUE_W-1:0]   data_value,
    output logic [1:0]                            status,
    input  logic                                  cfg_write,
    input  logic                                  cfg_index,
    input  logic [smsl_pkg::COUNT_W-1:0]          cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);

    logic [smsl_pkg::COUNT_W-1:0] row_count_reg;
    logic [smsl_pkg::COUNT_W-1:0] column_count_reg;

    logic                                res_valid;
    logic                                res_take;
    logic signed [smsl_pkg::VALUE_W-1:0] res_value;
    logic [1:0]                          res_status;

    logic                                out_valid_reg;
    logic signed [smsl_pkg::VALUE_W-1:0] data_value_reg;
    logic [1:0]                          status_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    smsl_pkg::entry_t rd_entry;
    logic [LW-1:0]    rd_link;
    logic             ent_wr_en;
    logic [AW-1:0]    ent_wr_addr;
    smsl_pkg::entry_t ent_wr_data;
    logic             link_wr_en;
    logic [AW-1:0]    link_wr_addr;
    logic [LW-1:0]    link_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= smsl_pkg::COUNT_RESET;
            column_count_reg <= smsl_pkg::COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                smsl_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                smsl_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:                    row_count_reg    <= row_count_reg;
            endcase
        end
    end

    smsl_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .LW       (LW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .row          (row),
        .col          (col),
        .new_value    (new_value),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res_value    (res_value),
        .res_status   (res_status),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_entry     (rd_entry),
        .rd_link      (rd_link),
        .ent_wr_en    (ent_wr_en),
        .ent_wr_addr  (ent_wr_addr),
        .ent_wr_data  (ent_wr_data),
        .link_wr_en   (link_wr_en),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data)
    );

    smsl_mem #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .LW       (LW)
    ) u_mem (
        .clk          (clk),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_entry     (rd_entry),
        .rd_link      (rd_link),
        .ent_wr_en    (ent_wr_en),
        .ent_wr_addr  (ent_wr_addr),
        .ent_wr_data  (ent_wr_data),
        .link_wr_en   (link_wr_en),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data)
    );

    // hand the result over once the output register is free or draining
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            data_value_reg <= res_value;
            status_reg     <= res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_value = data_value_reg;
    assign status     = status_reg;

endmodule
